### sv/single_block_write_back_cache_core_assert.svh
// assertion macros for the single block write-back cache core
// the clock is clk and the asynchronous reset is arst_n, both taken from the using scope
`ifndef SINGLE_BLOCK_WRITE_BACK_CACHE_CORE_ASSERT_SVH
`define SINGLE_BLOCK_WRITE_BACK_CACHE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// expression that holds at every clock edge out of reset
`define SBC_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define SBC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SBC_ASSERT_ALWAYS(lbl, expr, msg)
`define SBC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

### sv/sbc_pkg.sv
package sbc_pkg;

	// geometry
	localparam int SECTOR_WORDS          = 64;
	localparam int MAX_SECTORS_PER_BLOCK = 8;
	localparam int BUF_WORDS             = MAX_SECTORS_PER_BLOCK * SECTOR_WORDS;
	localparam int SW_W                  = $clog2(SECTOR_WORDS);
	localparam int SEC_W                 = $clog2(MAX_SECTORS_PER_BLOCK);
	localparam int BUF_AW                = $clog2(BUF_WORDS);
	localparam int LG_W                  = 2;
	localparam int LBA_W                 = 32;
	localparam int WORD_W                = 64;
	localparam int REQ_W                 = 3;
	localparam int KIND_W                = 3;
	localparam int STATUS_W              = 2;
	localparam int PHASE_W               = 2;

	localparam logic [LG_W-1:0] LG_RESET = 2'd3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DRAIN   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_FILL    = 3'd5;
	localparam logic [REQ_W-1:0] REQ_STATUS  = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_RDATA  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WSTART = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RSTART = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WBWORD = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;

	// sequencer phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
	localparam logic [PHASE_W-1:0] PH_WB_MISS  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_FILL     = 2'd2;
	localparam logic [PHASE_W-1:0] PH_WB_FLUSH = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BUF_AW-1:0] buf_addr_t;

	// one accepted request beat
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [LBA_W-1:0] lba;
		logic [SW_W-1:0]  sector_word;
		buf_addr_t        block_word;
		word_t            data;
		logic             flash_ok;
	} req_item_t;

	// buffer access for one beat
	typedef struct packed {
		logic      re;
		logic      we;
		buf_addr_t addr;
		word_t     wdata;
	} mem_cmd_t;

	// result descriptor; the data word joins it from the buffer's registered read data
	typedef struct packed {
		logic                valid;
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
		logic [LBA_W-1:0]    flash_block;
		logic                use_mem;
	} res_t;

	// buffer word of a sector access: sector within block over word within sector
	function automatic buf_addr_t buf_index(input logic [LBA_W-1:0] lba,
			input logic [LG_W-1:0] lg, input logic [SW_W-1:0] sw);
		logic [SEC_W-1:0] mask;
		logic [SEC_W-1:0] sec;
		mask = ~({SEC_W{1'b1}} << lg);
		sec  = lba[SEC_W-1:0] & mask;
		return {sec, sw};
	endfunction

endpackage

### sv/sbc_if.sv
// request channel
interface sbc_req_if;
	import sbc_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [LBA_W-1:0]    lba;
	logic [SW_W-1:0]     sector_word;
	logic [BUF_AW-1:0]   block_word;
	logic [WORD_W-1:0]   data;
	logic                flash_ok;

	modport source (output valid, req_type, lba, sector_word, block_word, data, flash_ok,
		input ready);
	modport sink (input valid, req_type, lba, sector_word, block_word, data, flash_ok,
		output ready);
endinterface

// result channel
interface sbc_rsp_if;
	import sbc_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [STATUS_W-1:0] status;
	logic [LBA_W-1:0]    flash_block;
	logic [WORD_W-1:0]   word_out;

	modport source (output valid, kind, status, flash_block, word_out, input ready);
	modport sink (input valid, kind, status, flash_block, word_out, output ready);
endinterface

### sv/sbc_ram.sv
module sbc_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read data held until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/sbc_ctrl.sv
module sbc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sbc_pkg::LG_W-1:0]  cfg_wdata,
	input  logic                      fire,
	input  sbc_pkg::req_item_t        item,
	output sbc_pkg::mem_cmd_t         mem_cmd,
	output sbc_pkg::res_t             res
);
	import sbc_pkg::*;

	logic [LG_W-1:0]    lg_q;
	logic [LBA_W-1:0]   held_block_q, held_block_d;
	logic               held_valid_q, held_valid_d;
	logic               held_dirty_q, held_dirty_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic               pend_write_q, pend_write_d;
	logic [LBA_W-1:0]   pend_lba_q, pend_lba_d;
	logic [SW_W-1:0]    pend_word_q, pend_word_d;
	word_t              pend_data_q, pend_data_d;

	logic [LBA_W-1:0]   item_blk;
	logic [LBA_W-1:0]   pend_blk;
	logic               hit;
	mem_cmd_t           cmd;

	// block numbers and hit test
	assign item_blk = item.lba >> lg_q;
	assign pend_blk = pend_lba_q >> lg_q;
	assign hit      = held_valid_q && (item_blk == held_block_q);

	// per-beat decode: tag update, buffer access, result descriptor
	always_comb begin
		held_block_d = held_block_q;
		held_valid_d = held_valid_q;
		held_dirty_d = held_dirty_q;
		phase_d      = phase_q;
		pend_write_d = pend_write_q;
		pend_lba_d   = pend_lba_q;
		pend_word_d  = pend_word_q;
		pend_data_d  = pend_data_q;
		cmd          = '0;
		res          = '0;
		res.valid    = 1'b1;
		res.kind     = KIND_DONE;
		res.status   = ST_OK;

		if (item.req_type <= REQ_DISCARD && phase_q != PH_IDLE) begin
			res.status = ST_BUSY;
		end else begin
			unique case (item.req_type) inside
				REQ_READ, REQ_WRITE: begin
					if (hit) begin
						cmd.addr  = buf_index(item.lba, lg_q, item.sector_word);
						cmd.wdata = item.data;
						if (item.req_type == REQ_WRITE) begin
							cmd.we       = 1'b1;
							held_dirty_d = 1'b1;
						end else begin
							cmd.re      = 1'b1;
							res.kind    = KIND_RDATA;
							res.use_mem = 1'b1;
						end
					end else begin
						pend_write_d = (item.req_type == REQ_WRITE);
						pend_lba_d   = item.lba;
						pend_word_d  = item.sector_word;
						pend_data_d  = item.data;
						if (held_valid_q && held_dirty_q) begin
							phase_d         = PH_WB_MISS;
							res.kind        = KIND_WSTART;
							res.flash_block = held_block_q;
						end else begin
							held_block_d    = item_blk;
							held_valid_d    = 1'b0;
							phase_d         = PH_FILL;
							res.kind        = KIND_RSTART;
							res.flash_block = item_blk;
						end
					end
				end
				REQ_FLUSH: begin
					if (held_valid_q && held_dirty_q) begin
						phase_d         = PH_WB_FLUSH;
						res.kind        = KIND_WSTART;
						res.flash_block = held_block_q;
					end
				end
				REQ_DISCARD: begin
					held_valid_d = 1'b0;
					held_dirty_d = 1'b0;
				end
				REQ_DRAIN: begin
					if (phase_q == PH_WB_MISS || phase_q == PH_WB_FLUSH) begin
						cmd.re      = 1'b1;
						cmd.addr    = item.block_word;
						res.kind    = KIND_WBWORD;
						res.use_mem = 1'b1;
					end else begin
						res.status = ST_BUSY;
					end
				end
				REQ_FILL: begin
					if (phase_q == PH_FILL) begin
						cmd.we    = 1'b1;
						cmd.addr  = item.block_word;
						cmd.wdata = item.data;
						res.valid = 1'b0;
					end else begin
						res.status = ST_BUSY;
					end
				end
				REQ_STATUS: begin
					unique case (phase_q)
						PH_WB_MISS: begin
							held_dirty_d = 1'b0;
							if (item.flash_ok) begin
								held_block_d    = pend_blk;
								held_valid_d    = 1'b0;
								phase_d         = PH_FILL;
								res.kind        = KIND_RSTART;
								res.flash_block = pend_blk;
							end else begin
								phase_d    = PH_IDLE;
								res.status = ST_FAIL;
							end
						end
						PH_WB_FLUSH: begin
							held_dirty_d = 1'b0;
							phase_d      = PH_IDLE;
							res.status   = item.flash_ok ? ST_OK : ST_FAIL;
						end
						PH_FILL: begin
							phase_d = PH_IDLE;
							if (!item.flash_ok) begin
								held_valid_d = 1'b0;
								res.status   = ST_FAIL;
							end else begin
								// complete the parked host access
								held_valid_d = 1'b1;
								held_dirty_d = 1'b0;
								cmd.addr     = buf_index(pend_lba_q, lg_q, pend_word_q);
								cmd.wdata    = pend_data_q;
								if (pend_write_q) begin
									cmd.we       = 1'b1;
									held_dirty_d = 1'b1;
								end else begin
									cmd.re      = 1'b1;
									res.kind    = KIND_RDATA;
									res.use_mem = 1'b1;
								end
							end
						end
						default: begin
							res.status = ST_BUSY;
						end
					endcase
				end
				default: begin
					res.status = ST_BUSY;
				end
			endcase
		end
	end

	// buffer strobes only on an accepted beat
	always_comb begin
		mem_cmd    = cmd;
		mem_cmd.re = cmd.re & fire;
		mem_cmd.we = cmd.we & fire;
	end

	// block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LG_RESET;
		end else if (cfg_we) begin
			lg_q <= cfg_wdata;
		end
	end

	// tag and pending access registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_block_q <= '0;
			held_valid_q <= 1'b0;
			held_dirty_q <= 1'b0;
			phase_q      <= PH_IDLE;
			pend_write_q <= 1'b0;
			pend_lba_q   <= '0;
			pend_word_q  <= '0;
			pend_data_q  <= '0;
		end else if (fire) begin
			held_block_q <= held_block_d;
			held_valid_q <= held_valid_d;
			held_dirty_q <= held_dirty_d;
			phase_q      <= phase_d;
			pend_write_q <= pend_write_d;
			pend_lba_q   <= pend_lba_d;
			pend_word_q  <= pend_word_d;
			pend_data_q  <= pend_data_d;
		end
	end

endmodule

### sv/single_block_write_back_cache_core.sv
// a result goes from its request beat through the buffer read stage and then the
// output register before it is offered
// throughput: one request beat per cycle while results are taken, the single
// buffer port with its registered read data sets the pace
// reset: arst_n clears tags, phase and pending access, block size goes to 8 sectors;
// the block buffer is not cleared
`include "single_block_write_back_cache_core_assert.svh"

module single_block_write_back_cache_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [sbc_pkg::LG_W-1:0] cfg_wdata,
	sbc_req_if.sink                  req,
	sbc_rsp_if.source                rsp
);
	import sbc_pkg::*;

	logic      fire;
	logic      s1_adv;
	req_item_t item;
	mem_cmd_t  mem_cmd;
	res_t      res;
	word_t     rdata;

	logic      s1_valid_q;
	res_t      res_s1;

	logic                rsp_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [STATUS_W-1:0] status_q;
	logic [LBA_W-1:0]    flash_block_q;
	word_t               word_out_q;

	// request beat
	assign item.req_type    = req.req_type;
	assign item.lba         = req.lba;
	assign item.sector_word = req.sector_word;
	assign item.block_word  = req.block_word;
	assign item.data        = req.data;
	assign item.flash_ok    = req.flash_ok;

	// the buffer stage moves on when the output register frees up
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_adv;
	assign fire      = req.valid && req.ready;

	sbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item),
		.mem_cmd   (mem_cmd),
		.res       (res)
	);

	sbc_ram #(
		.DEPTH (BUF_WORDS),
		.WIDTH (WORD_W)
	) u_buf (
		.clk   (clk),
		.re    (mem_cmd.re),
		.we    (mem_cmd.we),
		.addr  (mem_cmd.addr),
		.wdata (mem_cmd.wdata),
		.rdata (rdata)
	);

	// buffer read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			res_s1     <= '0;
		end else if (req.ready) begin
			s1_valid_q <= fire;
			res_s1     <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv && res_s1.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_s1.valid) begin
			kind_q        <= res_s1.kind;
			status_q      <= res_s1.status;
			flash_block_q <= res_s1.flash_block;
			word_out_q    <= res_s1.use_mem ? rdata : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.status      = status_q;
	assign rsp.flash_block = flash_block_q;
	assign rsp.word_out    = word_out_q;

	// checks
	`SBC_ASSERT_IMPLIES(a_stall_blocks_req, s1_valid_q && !s1_adv, !req.ready, "beat in a stall")
	`SBC_ASSERT_IMPLIES(a_mem_word_read, fire && res.use_mem, mem_cmd.re, "word used unread")
	`SBC_ASSERT_ALWAYS(a_one_access, !(mem_cmd.re && mem_cmd.we), "read and write in one beat")

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbc_pkg::*;

	// request code with no meaning to the block
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int RANDOM_BEATS = 1320;

	localparam word_t W_ONES = '1;
	localparam word_t W_A    = 64'h0123_4567_89ab_cdef;
	localparam word_t W_B    = 64'h9e37_79b9_7f4a_7c15;
	localparam word_t W_C    = 64'hc3c3_5a5a_0ff0_a55a;

	// block sizes visited by the random part, one per stretch
	localparam logic [LG_W-1:0] LG_PLAN [6] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3};

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
		logic [LBA_W-1:0]    flash_block;
		word_t               word_out;
	} answer_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_TABLE} row_check_t;

	typedef struct packed {
		req_item_t  beat;
		row_check_t check;
		answer_t    answer;
	} dir_row_t;

	// hand-made opening sequence, block size at its reset value of 8 sectors
	localparam dir_row_t DIRECTED [28] = '{
		'{'{REQ_READ, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_RSTART, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_FILL, 32'h0, 6'd0, 9'd0, W_ONES, 1'b0}, CHK_SILENT,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_WRITE, 32'hffff_ffff, 6'd63, 9'd0, W_C, 1'b1}, CHK_TABLE,
			'{KIND_DONE, ST_BUSY, 32'h0, 64'h0}},
		'{'{REQ_DRAIN, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_BUSY, 32'h0, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b1}, CHK_TABLE,
			'{KIND_RDATA, ST_OK, 32'h0, W_ONES}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b1}, CHK_TABLE,
			'{KIND_DONE, ST_BUSY, 32'h0, 64'h0}},
		'{'{REQ_UNUSED, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_BUSY, 32'h0, 64'h0}},
		'{'{REQ_FILL, 32'h0, 6'd0, 9'd0, W_C, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_BUSY, 32'h0, 64'h0}},
		'{'{REQ_WRITE, 32'h7, 6'd63, 9'd0, W_A, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_READ, 32'h7, 6'd63, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_RDATA, ST_OK, 32'h0, W_A}},
		'{'{REQ_READ, 32'hffff_ffff, 6'd63, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_WSTART, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_DRAIN, 32'h0, 6'd0, 9'd511, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_WBWORD, ST_OK, 32'h0, W_A}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b1}, CHK_TABLE,
			'{KIND_RSTART, ST_OK, 32'h1fff_ffff, 64'h0}},
		'{'{REQ_FILL, 32'h0, 6'd0, 9'd511, W_B, 1'b0}, CHK_SILENT,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b1}, CHK_TABLE,
			'{KIND_RDATA, ST_OK, 32'h0, W_B}},
		'{'{REQ_WRITE, 32'hffff_fff8, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_FLUSH, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_WSTART, ST_OK, 32'h1fff_ffff, 64'h0}},
		'{'{REQ_DRAIN, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_WBWORD, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_FAIL, 32'h0, 64'h0}},
		'{'{REQ_FLUSH, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_WRITE, 32'h8, 6'd5, 9'd0, W_C, 1'b0}, CHK_TABLE,
			'{KIND_RSTART, ST_OK, 32'h1, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b1}, CHK_MODEL,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_READ, 32'h10, 6'd1, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_WSTART, ST_OK, 32'h1, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_FAIL, 32'h0, 64'h0}},
		'{'{REQ_READ, 32'h8, 6'd5, 9'd0, 64'h0, 1'b0}, CHK_MODEL,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}},
		'{'{REQ_READ, 32'h28, 6'd2, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_RSTART, ST_OK, 32'h5, 64'h0}},
		'{'{REQ_STATUS, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_FAIL, 32'h0, 64'h0}},
		'{'{REQ_DISCARD, 32'h0, 6'd0, 9'd0, 64'h0, 1'b0}, CHK_TABLE,
			'{KIND_DONE, ST_OK, 32'h0, 64'h0}}
	};

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [LG_W-1:0] cfg_wdata;

	sbc_req_if req_if ();
	sbc_rsp_if rsp_if ();

	single_block_write_back_cache_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// shadow copy of the cache
	word_t               shadow_buf [BUF_WORDS];
	bit                  shadow_written [BUF_WORDS];
	buf_addr_t           filled_addrs [$];
	logic [LBA_W-1:0]    shadow_block = '0;
	bit                  shadow_valid = 1'b0;
	bit                  shadow_dirty = 1'b0;
	logic [PHASE_W-1:0]  shadow_phase = PH_IDLE;
	logic [LG_W-1:0]     shadow_lg    = LG_RESET;
	bit                  pend_write   = 1'b0;
	logic [LBA_W-1:0]    pend_lba     = '0;
	logic [SW_W-1:0]     pend_word    = '0;
	word_t               pend_data    = '0;

	answer_t     expected_answers [$];
	int unsigned mismatches = 0;
	int unsigned tx_calm    = 0;
	int unsigned rx_calm    = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("single_block_write_back_cache_core verification failed");
		$finish;
	end

	// idle cycles before a beat, with runs of back-to-back beats
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic answer_t make_answer(logic [KIND_W-1:0] k, logic [STATUS_W-1:0] s,
			logic [LBA_W-1:0] blk, word_t w);
		return '{k, s, blk, w};
	endfunction

	// sector within the block over word within the sector
	function automatic buf_addr_t word_index(logic [LBA_W-1:0] lba, logic [SW_W-1:0] sw);
		logic [SEC_W:0] mask;
		mask = ({{SEC_W{1'b0}}, 1'b1} << shadow_lg) - 1'b1;
		return {lba[SEC_W-1:0] & mask[SEC_W-1:0], sw};
	endfunction

	function automatic bit is_hit(logic [LBA_W-1:0] lba);
		return shadow_valid && ((lba >> shadow_lg) == shadow_block);
	endfunction

	function automatic void note_write(buf_addr_t a, word_t d);
		if (!shadow_written[a])
			filled_addrs.push_back(a);
		shadow_written[a] = 1'b1;
		shadow_buf[a]     = d;
	endfunction

	function automatic answer_t touch_word(bit wr, logic [LBA_W-1:0] lba,
			logic [SW_W-1:0] sw, word_t d);
		buf_addr_t a;
		a = word_index(lba, sw);
		if (!wr)
			return make_answer(KIND_RDATA, ST_OK, '0, shadow_buf[a]);
		note_write(a, d);
		shadow_dirty = 1'b1;
		return make_answer(KIND_DONE, ST_OK, '0, '0);
	endfunction

	function automatic answer_t open_fill();
		shadow_block = pend_lba >> shadow_lg;
		shadow_valid = 1'b0;
		shadow_phase = PH_FILL;
		return make_answer(KIND_RSTART, ST_OK, shadow_block, '0);
	endfunction

	// a successful fill may only complete a read whose word holds data
	function automatic bit fill_is_safe();
		return pend_write || shadow_written[word_index(pend_lba, pend_word)];
	endfunction

	// next state of the cache and the answer to one request beat
	function automatic bit predict_cache(input req_item_t b, output answer_t ans);
		ans = make_answer(KIND_DONE, ST_BUSY, '0, '0);
		if (b.req_type <= REQ_DISCARD && shadow_phase != PH_IDLE)
			return 1'b1;
		case (b.req_type) inside
			REQ_READ, REQ_WRITE: begin
				if (is_hit(b.lba)) begin
					ans = touch_word(b.req_type == REQ_WRITE, b.lba, b.sector_word, b.data);
				end else begin
					pend_write = (b.req_type == REQ_WRITE);
					pend_lba   = b.lba;
					pend_word  = b.sector_word;
					pend_data  = b.data;
					if (shadow_valid && shadow_dirty) begin
						shadow_phase = PH_WB_MISS;
						ans = make_answer(KIND_WSTART, ST_OK, shadow_block, '0);
					end else begin
						ans = open_fill();
					end
				end
			end
			REQ_FLUSH: begin
				if (shadow_valid && shadow_dirty) begin
					shadow_phase = PH_WB_FLUSH;
					ans = make_answer(KIND_WSTART, ST_OK, shadow_block, '0);
				end else begin
					ans = make_answer(KIND_DONE, ST_OK, '0, '0);
				end
			end
			REQ_DISCARD: begin
				shadow_valid = 1'b0;
				shadow_dirty = 1'b0;
				ans = make_answer(KIND_DONE, ST_OK, '0, '0);
			end
			REQ_DRAIN: begin
				if (shadow_phase == PH_WB_MISS || shadow_phase == PH_WB_FLUSH)
					ans = make_answer(KIND_WBWORD, ST_OK, '0, shadow_buf[b.block_word]);
			end
			REQ_FILL: begin
				if (shadow_phase == PH_FILL) begin
					note_write(b.block_word, b.data);
					return 1'b0;
				end
			end
			REQ_STATUS: begin
				case (shadow_phase)
					PH_WB_MISS: begin
						shadow_dirty = 1'b0;
						if (b.flash_ok) begin
							ans = open_fill();
						end else begin
							shadow_phase = PH_IDLE;
							ans = make_answer(KIND_DONE, ST_FAIL, '0, '0);
						end
					end
					PH_WB_FLUSH: begin
						shadow_dirty = 1'b0;
						shadow_phase = PH_IDLE;
						ans = make_answer(KIND_DONE, b.flash_ok ? ST_OK : ST_FAIL, '0, '0);
					end
					PH_FILL: begin
						shadow_phase = PH_IDLE;
						if (!b.flash_ok) begin
							shadow_valid = 1'b0;
							ans = make_answer(KIND_DONE, ST_FAIL, '0, '0);
						end else begin
							shadow_valid = 1'b1;
							shadow_dirty = 1'b0;
							ans = touch_word(pend_write, pend_lba, pend_word, pend_data);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return 1'b1;
	endfunction

	// random beat shaped by the phase the cache is in
	function automatic req_item_t next_beat();
		req_item_t   it;
		int unsigned pick;
		bit          safe;
		it.req_type    = REQ_W'($urandom_range(0, 7));
		it.lba         = $urandom;
		it.sector_word = SW_W'($urandom);
		it.block_word  = BUF_AW'($urandom);
		it.flash_ok    = 1'($urandom);
		case ($urandom_range(0, 15))
			0: it.data = '0;
			1: it.data = '1;
			default: it.data = {$urandom, $urandom};
		endcase
		pick = $urandom_range(0, 99);
		case (shadow_phase)
			PH_IDLE: begin
				if (pick < 6) begin
					it.req_type = REQ_W'($urandom_range(REQ_DRAIN, REQ_UNUSED));
				end else if (pick < 10) begin
					it.req_type = REQ_FLUSH;
				end else if (pick < 13) begin
					it.req_type = REQ_DISCARD;
				end else begin
					it.req_type = (pick < 55) ? REQ_WRITE : REQ_READ;
					// mostly the held block, sometimes a small neighbourhood
					case ($urandom_range(0, 3)) inside
						0, 1: begin
							if (shadow_valid)
								it.lba = (shadow_block << shadow_lg)
									| (it.lba & ((32'd1 << shadow_lg) - 32'd1));
						end
						2: it.lba = $urandom_range(0, 95);
						default: ;
					endcase
					if (it.req_type == REQ_READ && is_hit(it.lba)
							&& !shadow_written[word_index(it.lba, it.sector_word)])
						it.req_type = REQ_WRITE;
				end
			end
			PH_FILL: begin
				safe = fill_is_safe();
				if (pick < 10 && safe) begin
					it.req_type = REQ_STATUS;
					it.flash_ok = ($urandom_range(0, 7) != 0);
				end else if (pick >= 10 && pick < 18) begin
					while (it.req_type inside {REQ_FILL, REQ_STATUS})
						it.req_type = REQ_W'($urandom_range(0, 7));
				end else begin
					it.req_type = REQ_FILL;
					if (!safe && (pick < 10 || $urandom_range(0, 1) == 0))
						it.block_word = word_index(pend_lba, pend_word);
					else if ($urandom_range(0, 9) != 0)
						it.block_word = BUF_AW'(it.block_word % (SECTOR_WORDS << shadow_lg));
				end
			end
			default: begin
				// writeback: drains of words that hold data, then the status
				if (pick < 12 || filled_addrs.size() == 0) begin
					it.req_type = REQ_STATUS;
					it.flash_ok = ($urandom_range(0, 9) != 0);
				end else if (pick < 22) begin
					while (it.req_type inside {REQ_DRAIN, REQ_STATUS})
						it.req_type = REQ_W'($urandom_range(0, 7));
				end else begin
					it.req_type = REQ_DRAIN;
					if (!shadow_written[it.block_word])
						it.block_word = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
				end
			end
		endcase
		return it;
	endfunction

	// present one beat after a random gap and hold it until taken
	task automatic send_beat(input req_item_t beat);
		int unsigned gap;
		gap = draw_wait(tx_calm);
		@(negedge clk);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= beat.req_type;
		req_if.lba         <= beat.lba;
		req_if.sector_word <= beat.sector_word;
		req_if.block_word  <= beat.block_word;
		req_if.data        <= beat.data;
		req_if.flash_ok    <= beat.flash_ok;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic issue(input req_item_t beat);
		answer_t ans;
		if (predict_cache(beat, ans))
			expected_answers.push_back(ans);
		send_beat(beat);
	endtask

	// stop sending and let every outstanding answer come back
	task automatic wait_quiet();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic flag(input string note, input answer_t want, input answer_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected kind %0d status %0d block %h word %h",
				note, want.kind, want.status, want.flash_block, want.word_out);
			$display("%s: got kind %0d status %0d block %h word %h",
				note, got.kind, got.status, got.flash_block, got.word_out);
		end
	endtask

	// result side: random stalls, compare every beat with the oldest answer
	initial begin : answer_check
		int unsigned stall;
		answer_t     got;
		answer_t     want;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = draw_wait(rx_calm);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			got = '{rsp_if.kind, rsp_if.status, rsp_if.flash_block, rsp_if.word_out};
			if (expected_answers.size() == 0) begin
				flag("unexpected result", '0, got);
			end else begin
				want = expected_answers.pop_front();
				if (got !== want)
					flag("result mismatch", want, got);
			end
		end
	end

	// reset, directed table, then random stretches at several block sizes
	initial begin : stimulus
		req_item_t beat;
		answer_t   ans;
		bit        has;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_if.valid       = 1'b0;
		req_if.req_type    = REQ_READ;
		req_if.lba         = '0;
		req_if.sector_word = '0;
		req_if.block_word  = '0;
		req_if.data        = '0;
		req_if.flash_ok    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (DIRECTED[i]) begin
			has = predict_cache(DIRECTED[i].beat, ans);
			case (DIRECTED[i].check)
				CHK_TABLE: expected_answers.push_back(DIRECTED[i].answer);
				CHK_MODEL: if (has) expected_answers.push_back(ans);
				default: ;
			endcase
			send_beat(DIRECTED[i].beat);
		end

		foreach (LG_PLAN[p]) begin
			// block size only changes with the cache idle and nothing in flight
			wait_quiet();
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= LG_PLAN[p];
			@(negedge clk);
			cfg_we    <= 1'b0;
			shadow_lg = LG_PLAN[p];
			repeat (RANDOM_BEATS / $size(LG_PLAN)) issue(next_beat());
			// close any open writeback or fill with status beats
			while (shadow_phase != PH_IDLE) begin
				beat          = next_beat();
				beat.req_type = REQ_STATUS;
				beat.flash_ok = (shadow_phase != PH_FILL) || fill_is_safe();
				issue(beat);
			end
		end

		wait_quiet();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("single_block_write_back_cache_core verification clean");
		else
			$display("single_block_write_back_cache_core verification failed");
		$finish;
	end

endmodule
